[hdl/pwag_pkg.sv]
// shared types, constants and helper functions of the window address generator
package pwag_pkg;

    localparam int CFG_W          = 11;
    localparam int DIM_W          = 11;
    localparam int KER_W          = 4;
    localparam int PAD_W          = 3;
    localparam int COORD_W        = 10;
    localparam int POS_W          = 20;
    localparam int OFS_W          = 3;
    localparam int RAW_W          = 16;
    localparam int Q_DEPTH        = 4;
    localparam int MAX_DIM_DEF    = 1024;
    localparam int MAX_KERNEL_DEF = 8;

    typedef enum logic [2:0] {
        CFG_INPUT_HEIGHT  = 3'd0,
        CFG_INPUT_WIDTH   = 3'd1,
        CFG_KERNEL_HEIGHT = 3'd2,
        CFG_KERNEL_WIDTH  = 3'd3,
        CFG_STRIDE_HEIGHT = 3'd4,
        CFG_STRIDE_WIDTH  = 3'd5,
        CFG_PAD_TOP       = 3'd6,
        CFG_PAD_LEFT      = 3'd7
    } t_cfg_idx;

    // stride and padding as written
    typedef struct packed {
        logic [KER_W-1:0] row_stride;
        logic [KER_W-1:0] col_stride;
        logic [PAD_W-1:0] pad_top;
        logic [PAD_W-1:0] pad_left;
    } t_step;

    // sizes after saturation
    typedef struct packed {
        logic [DIM_W-1:0] h_size;
        logic [DIM_W-1:0] w_size;
        logic [KER_W-1:0] kh;
        logic [KER_W-1:0] kw;
    } t_geom;

    typedef struct packed {
        logic [DIM_W-1:0] start;
        logic [KER_W-1:0] cnt;
        logic             ok;
    } t_axis;

    // one window request between front and back
    typedef struct packed {
        logic [POS_W-1:0] start_pos;
        logic [KER_W-1:0] nr;
        logic [KER_W-1:0] nc;
        logic             empty;
    } t_win_req;

    function automatic logic [DIM_W-1:0] sat_dim(logic [DIM_W-1:0] v, int hi);
        logic [DIM_W-1:0] res;
        res = v;
        if (int'(v) > hi) begin
            res = DIM_W'(hi);
        end
        return res;
    endfunction

    function automatic logic [KER_W-1:0] sat_ker(logic [KER_W-1:0] v, int hi);
        logic [KER_W-1:0] res;
        res = v;
        if (int'(v) > hi) begin
            res = KER_W'(hi);
        end
        return res;
    endfunction

    // clamp at the top/left padding, clip at the far edge
    function automatic t_axis clip_axis(logic signed [RAW_W-1:0] raw,
                                        logic [KER_W-1:0] kern,
                                        logic [DIM_W-1:0] size);
        logic signed [RAW_W-1:0] s;
        logic signed [RAW_W-1:0] n;
        logic signed [RAW_W-1:0] k;
        logic signed [RAW_W-1:0] sz;
        t_axis                   res;
        k  = $signed({{(RAW_W-KER_W){1'b0}}, kern});
        sz = $signed({{(RAW_W-DIM_W){1'b0}}, size});
        if (raw < 0) begin
            s = '0;
            n = k + raw;
        end else begin
            s = raw;
            n = k;
        end
        if (s + n > sz) begin
            n = sz - s;
        end
        res.start = s[DIM_W-1:0];
        res.cnt   = n[KER_W-1:0];
        res.ok    = (n > 0);
        return res;
    endfunction

endpackage

[hdl/pwag_front.sv]
// front pipeline: window origin, clipping and start position of each request
module pwag_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pwag_pkg::t_step                 i_step,
    input  pwag_pkg::t_geom                 i_geom,
    input  logic                            i_vld,
    input  logic [pwag_pkg::COORD_W-1:0]    i_out_row,
    input  logic [pwag_pkg::COORD_W-1:0]    i_out_col,
    output logic                            o_stall,
    input  logic                            i_q_full,
    output logic                            o_push,
    output pwag_pkg::t_win_req              o_req
);
    import pwag_pkg::*;

    localparam int PROD_W = COORD_W + KER_W;

    logic                      adv;
    logic                      acc;
    logic [PROD_W-1:0]         prod_r;
    logic [PROD_W-1:0]         prod_c;
    t_axis                     ax_r;
    t_axis                     ax_c;
    logic [2*DIM_W-1:0]        row_base;

    logic                      r_v1, r_v2, r_v3;
    logic signed [RAW_W-1:0]   r_raw_r, r_raw_c;
    t_axis                     r_ax_r, r_ax_c;
    t_win_req                  r_req;

    // the pipe only holds when a finished request cannot enter the queue
    assign adv     = !(r_v3 && i_q_full);
    assign acc     = i_vld && adv;
    assign o_stall = !adv;
    assign o_push  = r_v3 && !i_q_full;
    assign o_req   = r_req;

    assign prod_r = PROD_W'(i_out_row) * PROD_W'(i_step.row_stride);
    assign prod_c = PROD_W'(i_out_col) * PROD_W'(i_step.col_stride);

    assign ax_r = clip_axis(r_raw_r, i_geom.kh, i_geom.h_size);
    assign ax_c = clip_axis(r_raw_c, i_geom.kw, i_geom.w_size);

    assign row_base = (2*DIM_W)'(r_ax_r.start) * (2*DIM_W)'(i_geom.w_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_raw_r <= $signed({{(RAW_W-PROD_W){1'b0}}, prod_r})
                     - $signed({{(RAW_W-PAD_W){1'b0}}, i_step.pad_top});
            r_raw_c <= $signed({{(RAW_W-PROD_W){1'b0}}, prod_c})
                     - $signed({{(RAW_W-PAD_W){1'b0}}, i_step.pad_left});
            r_ax_r  <= ax_r;
            r_ax_c  <= ax_c;
            r_req.start_pos <= row_base[POS_W-1:0] + POS_W'(r_ax_c.start);
            r_req.nr        <= r_ax_r.cnt;
            r_req.nc        <= r_ax_c.cnt;
            r_req.empty     <= !(r_ax_r.ok && r_ax_c.ok);
        end
    end

endmodule

[hdl/pwag_queue.sv]
// short request queue between front and back
module pwag_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  pwag_pkg::t_win_req   i_req,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_vld,
    output pwag_pkg::t_win_req   o_req
);
    import pwag_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_win_req          r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_pop;

    assign o_full = (r_count == CNT_W'(Q_DEPTH));
    assign o_vld  = (r_count != '0);
    assign o_req  = r_mem[r_rd_ptr];
    assign do_pop = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule

[hdl/pwag_back.sv]
// back end: walks the clipped window and drives the result register
module pwag_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [pwag_pkg::DIM_W-1:0]     i_row_step,
    input  logic                           i_q_vld,
    input  pwag_pkg::t_win_req             i_q_req,
    output logic                           o_pop,
    output logic                           o_vld,
    input  logic                           i_stall,
    output logic [pwag_pkg::POS_W-1:0]     o_input_position,
    output logic [pwag_pkg::OFS_W-1:0]     o_window_row,
    output logic [pwag_pkg::OFS_W-1:0]     o_window_col,
    output logic                           o_empty_window,
    output logic                           o_last
);
    import pwag_pkg::*;

    logic               r_busy;
    logic [OFS_W-1:0]   r_h, r_w;
    logic [POS_W-1:0]   r_pos, r_row_pos;
    logic [KER_W-1:0]   r_nr, r_nc;
    logic               r_empty;
    logic               r_o_vld;

    logic               out_ld;
    logic               col_last;
    logic               row_last;
    logic               is_last;
    logic [POS_W-1:0]   next_row_pos;

    assign out_ld       = r_busy && (!r_o_vld || !i_stall);
    assign col_last     = ({1'b0, r_w} == r_nc - 1'b1);
    assign row_last     = ({1'b0, r_h} == r_nr - 1'b1);
    assign is_last      = r_empty || (row_last && col_last);
    assign o_pop        = i_q_vld && (!r_busy || (out_ld && is_last));
    assign next_row_pos = r_row_pos + POS_W'(i_row_step);
    assign o_vld        = r_o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (out_ld) begin
                r_o_vld <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (out_ld && is_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ld) begin
            o_input_position <= r_empty ? '0 : r_pos;
            o_window_row     <= r_empty ? '0 : r_h;
            o_window_col     <= r_empty ? '0 : r_w;
            o_empty_window   <= r_empty;
            o_last           <= is_last;
        end
        if (o_pop) begin
            r_h       <= '0;
            r_w       <= '0;
            r_pos     <= i_q_req.start_pos;
            r_row_pos <= i_q_req.start_pos;
            r_nr      <= i_q_req.nr;
            r_nc      <= i_q_req.nc;
            r_empty   <= i_q_req.empty;
        end else if (out_ld && !is_last) begin
            if (col_last) begin
                // next window row starts one input row further on
                r_h       <= r_h + 1'b1;
                r_w       <= '0;
                r_row_pos <= next_row_pos;
                r_pos     <= next_row_pos;
            end else begin
                r_w   <= r_w + 1'b1;
                r_pos <= r_pos + 1'b1;
            end
        end
    end

endmodule

[hdl/pool_window_address_generator_core.sv]
// Window address generator: each request (out_row, out_col) yields the linear input
// positions of its kernel window, row by row, clamped at the top/left padding and
// clipped at the bottom/right input edges; a window with no pixels yields one result
// flagged empty. A request produces max(1, rows*cols) results, from 1 to 64, one per
// cycle from the walking counter in the back end when the output is not stalled.
// Requests pass a three-stage front pipeline (origin multiply, clipping, start-position
// multiply) and a four-entry queue, so new requests keep being taken while a window is
// still being emitted. No clearing pass after reset.
module pool_window_address_generator_core #(
    parameter int MAX_DIM    = pwag_pkg::MAX_DIM_DEF,
    parameter int MAX_KERNEL = pwag_pkg::MAX_KERNEL_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [2:0]                     i_cfg_idx,
    input  logic [pwag_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_vld,
    output logic                           o_stall,
    input  logic [pwag_pkg::COORD_W-1:0]   i_out_row,
    input  logic [pwag_pkg::COORD_W-1:0]   i_out_col,
    output logic                           o_vld,
    input  logic                           i_stall,
    output logic [pwag_pkg::POS_W-1:0]     o_input_position,
    output logic [pwag_pkg::OFS_W-1:0]     o_window_row,
    output logic [pwag_pkg::OFS_W-1:0]     o_window_col,
    output logic                           o_empty_window,
    output logic                           o_last
);
    import pwag_pkg::*;

    logic [DIM_W-1:0]  r_in_h, r_in_w;
    logic [KER_W-1:0]  r_ker_h, r_ker_w;
    t_step             r_step;
    t_geom             geom;

    logic              q_full, q_vld, push, pop;
    t_win_req          f_req, q_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_h            <= DIM_W'(1);
            r_in_w            <= DIM_W'(1);
            r_ker_h           <= KER_W'(1);
            r_ker_w           <= KER_W'(1);
            r_step.row_stride <= KER_W'(1);
            r_step.col_stride <= KER_W'(1);
            r_step.pad_top    <= '0;
            r_step.pad_left   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_INPUT_HEIGHT:  r_in_h            <= i_cfg_data[DIM_W-1:0];
                CFG_INPUT_WIDTH:   r_in_w            <= i_cfg_data[DIM_W-1:0];
                CFG_KERNEL_HEIGHT: r_ker_h           <= i_cfg_data[KER_W-1:0];
                CFG_KERNEL_WIDTH:  r_ker_w           <= i_cfg_data[KER_W-1:0];
                CFG_STRIDE_HEIGHT: r_step.row_stride <= i_cfg_data[KER_W-1:0];
                CFG_STRIDE_WIDTH:  r_step.col_stride <= i_cfg_data[KER_W-1:0];
                CFG_PAD_TOP:       r_step.pad_top    <= i_cfg_data[PAD_W-1:0];
                CFG_PAD_LEFT:      r_step.pad_left   <= i_cfg_data[PAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign geom.h_size = sat_dim(r_in_h, MAX_DIM);
    assign geom.w_size = sat_dim(r_in_w, MAX_DIM);
    assign geom.kh     = sat_ker(r_ker_h, MAX_KERNEL);
    assign geom.kw     = sat_ker(r_ker_w, MAX_KERNEL);

    pwag_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (r_step),
        .i_geom    (geom),
        .i_vld     (i_vld),
        .i_out_row (i_out_row),
        .i_out_col (i_out_col),
        .o_stall   (o_stall),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_req     (f_req)
    );

    pwag_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (f_req),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_vld   (q_vld),
        .o_req   (q_req)
    );

    pwag_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_row_step       (geom.w_size),
        .i_q_vld          (q_vld),
        .i_q_req          (q_req),
        .o_pop            (pop),
        .o_vld            (o_vld),
        .i_stall          (i_stall),
        .o_input_position (o_input_position),
        .o_window_row     (o_window_row),
        .o_window_col     (o_window_col),
        .o_empty_window   (o_empty_window),
        .o_last           (o_last)
    );

`ifndef SYNTHESIS
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld && o_empty_window |-> o_last && (o_input_position == '0))
        else $error("empty window result must be single and zeroed");

    a_offset_in_kernel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld && !o_empty_window |->
            ({1'b0, o_window_row} < geom.kh) && ({1'b0, o_window_col} < geom.kw))
        else $error("window offset outside kernel");

    a_offset_in_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld && !o_empty_window |->
            ({1'b0, o_window_row} < geom.h_size) && ({1'b0, o_window_col} < geom.w_size))
        else $error("window offset outside input");
`endif

endmodule
